// File: hdl/jpdt_pkg.sv
// shared types, constants and fixed-point helpers for the joint pd torque core
package jpdt_pkg;

  localparam int JOINT_COUNT = 7;
  localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 25;

  localparam logic [1:0] MODE_POLICY   = 2'd0;
  localparam logic [1:0] MODE_PLAYBACK = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_DAMPING    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE_STEP = 3'd5;

  localparam logic [2:0] LAST_GAIN_ROW = 3'd6;

  localparam logic [24:0] KP_TAB [7] = '{
    25'd26214400, 25'd26214400, 25'd26214400, 25'd19660800,
    25'd3932160, 25'd2621440, 25'd655360
  };
  localparam logic [24:0] KD_TAB [7] = '{
    25'd3276800, 25'd3276800, 25'd3276800, 25'd2837792,
    25'd1269099, 25'd1036215, 25'd518108
  };

  typedef struct packed {
    logic [1:0]  control_mode;
    logic [16:0] max_target_step;
    logic [16:0] playback_gain;
    logic [16:0] policy_gain;
    logic [16:0] free_damping;
    logic [24:0] max_torque_step;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DELTA,
    OP_MULG,
    OP_UPDF,
    OP_ERR,
    OP_MULKP,
    OP_SUM,
    OP_FMUL,
    OP_FSUM,
    OP_SLEW,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic free_mode;
    logic out_busy;
  } dp_status_t;

  // saturate a 35 bit signed value to 32 bits
  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] != {4{v[31]}}) begin
      r = v[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round a q34.32 product to q16.16, ties toward +inf, then saturate
  function automatic logic signed [31:0] qround(input logic signed [65:0] p);
    logic signed [66:0] s;
    logic signed [50:0] t;
    logic signed [31:0] r;
    s = 67'(p) + 67'sd32768;
    t = s[66:16];
    if (t[50:31] != {20{t[31]}}) begin
      r = t[50] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/joint_pd_torque_with_slew_limits_core.sv
// top level: joint pd torque controller with target smoothing and torque slew limit
// the sequencer steps one shared 33x33 multiplier through each item in tracking and free modes
// a new item is taken in only once the sequencer is through with the last one or has dropped it
// reset clears configuration to defaults, all seed flags and last torques to zero
// a result waits in the output register while the next item is taken in
module joint_pd_torque_with_slew_limits_core
  import jpdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // joint_index, target_position, measured_position, measured_velocity,
  // compensation_torque, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // target_valid
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_joint_index, torque_command, smoothed_target, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  jpdt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jpdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  jpdt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_flag   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: hdl/jpdt_regs.sv
// configuration register file
module jpdt_regs
  import jpdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode    <= MODE_POLICY;
      cfg.max_target_step <= 17'd6554;
      cfg.playback_gain   <= 17'd328;
      cfg.policy_gain     <= 17'd65536;
      cfg.free_damping    <= 17'd3277;
      cfg.max_torque_step <= 25'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONTROL_MODE:    cfg.control_mode    <= cfg_data[1:0];
        REG_MAX_TARGET_STEP: cfg.max_target_step <= cfg_data[16:0];
        REG_PLAYBACK_GAIN:   cfg.playback_gain   <= cfg_data[16:0];
        REG_POLICY_GAIN:     cfg.policy_gain     <= cfg_data[16:0];
        REG_FREE_DAMPING:    cfg.free_damping    <= cfg_data[16:0];
        REG_MAX_TORQUE_STEP: cfg.max_torque_step <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/jpdt_ctrl.sv
// sequencer state machine for one joint sample
module jpdt_ctrl
  import jpdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DELTA,
    S_MULG,
    S_UPDF,
    S_ERR,
    S_MULKP,
    S_SUM,
    S_FMUL,
    S_FSUM,
    S_SLEW,
    S_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
      S_CHECK: cmd.op = OP_NONE;
      S_DELTA: cmd.op = OP_DELTA;
      S_MULG:  cmd.op = OP_MULG;
      S_UPDF:  cmd.op = OP_UPDF;
      S_ERR:   cmd.op = OP_ERR;
      S_MULKP: cmd.op = OP_MULKP;
      S_SUM:   cmd.op = OP_SUM;
      S_FMUL:  cmd.op = OP_FMUL;
      S_FSUM:  cmd.op = OP_FSUM;
      S_SLEW:  cmd.op = OP_SLEW;
      S_DONE:  cmd.op = status.out_busy ? OP_NONE : OP_LOAD;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (status.drop) state <= S_IDLE;
          else if (status.free_mode) state <= S_FMUL;
          else state <= S_DELTA;
        end
        S_DELTA: state <= S_MULG;
        S_MULG:  state <= S_UPDF;
        S_UPDF:  state <= S_ERR;
        S_ERR:   state <= S_MULKP;
        S_MULKP: state <= S_SUM;
        S_SUM:   state <= S_SLEW;
        S_FMUL:  state <= S_FSUM;
        S_FSUM:  state <= S_SLEW;
        S_SLEW:  state <= S_DONE;
        S_DONE: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/jpdt_dp.sv
// datapath: joint state, shared multiplier, filter, pd law, slew limit, output register
module jpdt_dp
  import jpdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   in_flag,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic [2:0]         j_r;
  logic signed [31:0] tgt_r, q_r, dq_r, comp_r;
  logic               valid_r;
  logic signed [31:0] f_r, err_r, tau_r, cmd_r;
  logic signed [17:0] delta_r;
  logic signed [33:0] acc_r;
  logic signed [65:0] prod_r;

  logic signed [31:0] ft [JOINT_COUNT];
  logic               seeded [JOINT_COUNT];
  logic signed [31:0] last_t [JOINT_COUNT];

  logic [2:0]         out_j;
  logic signed [31:0] out_cmd, out_smooth;

  logic [JIDX_W-1:0]  jx;
  logic [2:0]         g;
  logic [16:0]        gain;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] rnd;
  logic signed [31:0] f_sel;
  logic signed [32:0] d33, tlim, tlim_n;
  logic signed [17:0] delta_n;
  logic signed [31:0] f_new;
  logic signed [32:0] s33, slim, slim_n, s_diff;
  logic signed [31:0] cmd_n;

  assign jx   = JIDX_W'(j_r);
  assign g    = (j_r > LAST_GAIN_ROW) ? LAST_GAIN_ROW : j_r;
  assign gain = (cfg.control_mode == MODE_PLAYBACK) ? cfg.playback_gain : cfg.policy_gain;
  assign rnd  = qround(prod_r);

  assign status.drop = (5'(j_r) >= 5'(JOINT_COUNT)) ||
                       ((cfg.control_mode == MODE_PLAYBACK) && !valid_r);
  assign status.free_mode = cfg.control_mode[1];
  assign status.out_busy  = out_valid && !out_ready;

  // target filter step
  always_comb begin
    f_sel  = seeded[jx] ? ft[jx] : q_r;
    d33    = 33'(tgt_r) - 33'(f_sel);
    tlim   = $signed({16'd0, cfg.max_target_step});
    tlim_n = -tlim;
    if (d33 > tlim) delta_n = 18'(tlim);
    else if (d33 < tlim_n) delta_n = 18'(tlim_n);
    else delta_n = 18'(d33);
    f_new = sat35(35'(f_r) + 35'(rnd));
  end

  // slew limit against last torque
  always_comb begin
    s33    = 33'(tau_r) - 33'(last_t[jx]);
    slim   = $signed({8'd0, cfg.max_torque_step});
    slim_n = -slim;
    if (s33 > slim) s_diff = slim;
    else if (s33 < slim_n) s_diff = slim_n;
    else s_diff = s33;
    cmd_n = sat35(35'(last_t[jx]) + 35'(s_diff));
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DELTA: begin
        mul_a = $signed({8'd0, KD_TAB[g]});
        mul_b = 33'(dq_r);
      end
      OP_MULG: begin
        mul_a = $signed({16'd0, gain});
        mul_b = 33'(delta_r);
      end
      OP_MULKP: begin
        mul_a = $signed({8'd0, KP_TAB[g]});
        mul_b = 33'(err_r);
      end
      OP_FMUL: begin
        mul_a = $signed({16'd0, cfg.free_damping});
        mul_b = 33'(dq_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        j_r     <= in_data[2:0];
        tgt_r   <= in_data[34:3];
        q_r     <= in_data[66:35];
        dq_r    <= in_data[98:67];
        comp_r  <= in_data[130:99];
        valid_r <= in_flag;
      end
      OP_DELTA: begin
        f_r     <= f_sel;
        delta_r <= delta_n;
        prod_r  <= mul_a * mul_b;
      end
      OP_MULG: begin
        acc_r  <= 34'(comp_r) - 34'(rnd);
        prod_r <= mul_a * mul_b;
      end
      OP_UPDF: begin
        f_r <= f_new;
        ft[jx] <= f_new;
      end
      OP_ERR: begin
        err_r <= sat35(35'(f_r) - 35'(q_r));
      end
      OP_MULKP: begin
        prod_r <= mul_a * mul_b;
      end
      OP_SUM: begin
        tau_r <= sat35(35'(acc_r) + 35'(rnd));
      end
      OP_FMUL: begin
        f_r    <= '0;
        prod_r <= mul_a * mul_b;
      end
      OP_FSUM: begin
        tau_r <= sat35(35'(comp_r) - 35'(rnd));
      end
      OP_SLEW: begin
        cmd_r <= cmd_n;
      end
      OP_LOAD: begin
        out_j      <= j_r;
        out_cmd    <= cmd_r;
        out_smooth <= f_r;
      end
      default: ;
    endcase
  end

  // per joint control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        seeded[i] <= 1'b0;
        last_t[i] <= '0;
      end
    end else begin
      if (cmd.op == OP_UPDF) seeded[jx] <= 1'b1;
      if (cmd.op == OP_SLEW) last_t[jx] <= cmd_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {5'd0, out_smooth, out_cmd, out_j};

endmodule
